>>> hw/rtl/piecewise_linear_interp_assert.svh
// assertion macros shared by the interpolation table modules
`ifndef PIECEWISE_LINEAR_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERP_ASSERT_SVH

// same-cycle implication, checked on clk and disabled in reset
`define PLI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and disabled in reset
`define PLI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/plin_pkg.sv
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package plin_pkg;

  // table geometry and field widths
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int TIME_W      = 32;
  localparam int VALUE_W     = 32;

  // product of slope magnitude and time offset, and divider step count
  localparam int PROD_W      = TIME_W + VALUE_W;
  localparam int DIV_STEPS   = VALUE_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // result region codes
  localparam logic [1:0] REGION_EMPTY  = 2'd0;
  localparam logic [1:0] REGION_FIRST  = 2'd1;
  localparam logic [1:0] REGION_LAST   = 2'd2;
  localparam logic [1:0] REGION_INTERP = 2'd3;

  // table read address select
  typedef enum logic [1:0] {
    ADDR_ZERO = 2'd0,
    ADDR_LAST = 2'd1,
    ADDR_ONE  = 2'd2,
    ADDR_NEXT = 2'd3
  } addr_sel_t;

  // result source select
  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_RD     = 2'd1,
    RES_LASTV  = 2'd2,
    RES_INTERP = 2'd3
  } res_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic       wr_en;
    logic       load_query;
    addr_sel_t  addr_sel;
    logic       save_prev;
    logic       save_last;
    logic       save_hit;
    logic       prep;
    logic       mul;
    logic       div_step;
    logic       res_load;
    res_sel_t   res_sel;
    logic [1:0] res_region;
    logic       out_load;
  } plin_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic n_zero;
    logic t_le_rd;
    logic t_ge_rd;
    logic rd_le_prev;
    logic k_last;
    logic div_last;
    logic out_free;
  } plin_status_t;

endpackage

>>> hw/rtl/plin_ctrl.sv
// sequencing state machine for table writes, search and interpolation
`timescale 1ns / 1ps
`include "piecewise_linear_interp_assert.svh"

module plin_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   mode,
  output logic                   in_stall,
  output logic                   cfg_ready,
  input  plin_pkg::plin_status_t status,
  output plin_pkg::plin_cmd_t    cmd
);
  import plin_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FIRST = 9'b000000010,
    S_LAST  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_PREP  = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // handshake: items and config only while idle
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.addr_sel   = ADDR_ZERO;
    cmd.res_sel    = RES_ZERO;
    cmd.res_region = REGION_EMPTY;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            if (status.n_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_sel    = RES_ZERO;
              cmd.res_region = REGION_EMPTY;
              state_next     = S_DONE;
            end else begin
              state_next = S_FIRST;
            end
          end
        end
      end
      // entry 0 on the read port
      S_FIRST: begin
        cmd.save_prev = 1'b1;
        if (status.t_le_rd) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_RD;
          cmd.res_region = REGION_FIRST;
          state_next     = S_DONE;
        end else begin
          cmd.addr_sel = ADDR_LAST;
          state_next   = S_LAST;
        end
      end
      // last entry in use on the read port
      S_LAST: begin
        cmd.save_last = 1'b1;
        if (status.t_ge_rd) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_RD;
          cmd.res_region = REGION_LAST;
          state_next     = S_DONE;
        end else begin
          cmd.addr_sel = ADDR_ONE;
          state_next   = S_SCAN;
        end
      end
      // entry k on the read port, look for the bracket
      S_SCAN: begin
        if (status.t_le_rd) begin
          cmd.save_hit = 1'b1;
          if (status.rd_le_prev) begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RES_RD;
            cmd.res_region = REGION_INTERP;
            state_next     = S_DONE;
          end else begin
            state_next = S_PREP;
          end
        end else begin
          cmd.save_prev = 1'b1;
          if (status.k_last) begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RES_LASTV;
            cmd.res_region = REGION_LAST;
            state_next     = S_DONE;
          end else begin
            cmd.addr_sel = ADDR_NEXT;
          end
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_INTERP;
        cmd.res_region = REGION_INTERP;
        state_next     = S_DONE;
      end
      // wait for the output register
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `PLI_ASSERT_NXT(a_eval_start, (accept && mode == MODE_EVAL), (state == S_FIRST || state == S_DONE), "evaluate item did not start a search")
  `PLI_ASSERT_NXT(a_div_hold, (state == S_DIV && !status.div_last), (state == S_DIV), "divider left before its last step")
  `PLI_ASSERT_NXT(a_done_hold, (state == S_DONE && !status.out_free), (state == S_DONE), "result dropped while output register full")

endmodule

>>> hw/rtl/plin_dp.sv
// breakpoint memory, compare, multiply, restoring divider and output register
`timescale 1ns / 1ps
`include "piecewise_linear_interp_assert.svh"

module plin_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  plin_pkg::plin_cmd_t                 cmd,
  output plin_pkg::plin_status_t              status,
  input  logic                                cfg_wr,
  input  logic [plin_pkg::CNT_W-1:0]          cfg_data,
  input  logic [plin_pkg::IDX_W-1:0]          entry_index,
  input  logic [plin_pkg::TIME_W-1:0]         entry_time,
  input  logic signed [plin_pkg::VALUE_W-1:0] entry_value,
  input  logic [plin_pkg::TIME_W-1:0]         query_time,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [plin_pkg::VALUE_W-1:0] value_out,
  output logic [1:0]                          region
);
  import plin_pkg::*;

  logic [CNT_W-1:0]          entry_count;
  logic [CNT_W-1:0]          n_use;
  logic [CNT_W-1:0]          n_m1;

  logic [TIME_W-1:0]         times_mem  [TABLE_DEPTH];
  logic [VALUE_W-1:0]        values_mem [TABLE_DEPTH];
  logic [IDX_W-1:0]          rd_addr;
  logic [TIME_W-1:0]         rd_time;
  logic [VALUE_W-1:0]        rd_val;
  logic [IDX_W-1:0]          k;

  logic [TIME_W-1:0]         t_q;
  logic [TIME_W-1:0]         prev_time;
  logic [VALUE_W-1:0]        prev_val;
  logic [TIME_W-1:0]         hit_time;
  logic [VALUE_W-1:0]        hit_val;
  logic [VALUE_W-1:0]        last_val;

  logic [VALUE_W:0]          dy;
  logic [VALUE_W:0]          dy_neg;
  logic [VALUE_W-1:0]        mag;
  logic                      neg;
  logic [TIME_W-1:0]         dx;
  logic [TIME_W-1:0]         den;

  logic [PROD_W-1:0]         prod;
  logic [TIME_W-1:0]         rem;
  logic [VALUE_W-1:0]        quo;
  logic [DCNT_W-1:0]         dcnt;
  logic [TIME_W:0]           rem_sh;
  logic [TIME_W:0]           rem_sub;
  logic                      q_bit;

  logic [VALUE_W+1:0]        interp;
  logic [VALUE_W-1:0]        res_mux;
  logic [VALUE_W-1:0]        res_val;
  logic [1:0]                res_region;

  // entries in use, capped at the table depth
  assign n_use = (entry_count > DEPTH_CNT) ? DEPTH_CNT : entry_count;
  assign n_m1  = n_use - CNT_W'(1);

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr) begin
      entry_count <= cfg_data;
    end
  end

  // read address
  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_ZERO: rd_addr = '0;
      ADDR_LAST: rd_addr = n_m1[IDX_W-1:0];
      ADDR_ONE:  rd_addr = IDX_W'(1);
      ADDR_NEXT: rd_addr = k + IDX_W'(1);
      default:   rd_addr = '0;
    endcase
  end

  // breakpoint memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      times_mem[entry_index]  <= entry_time;
      values_mem[entry_index] <= entry_value;
    end
    rd_time <= times_mem[rd_addr];
    rd_val  <= values_mem[rd_addr];
  end

  // search index follows the read address
  always_ff @(posedge clk) begin
    if (cmd.addr_sel == ADDR_ONE || cmd.addr_sel == ADDR_NEXT) begin
      k <= rd_addr;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      t_q <= query_time;
    end
    if (cmd.save_prev) begin
      prev_time <= rd_time;
      prev_val  <= rd_val;
    end
    if (cmd.save_last) begin
      last_val <= rd_val;
    end
    if (cmd.save_hit) begin
      hit_time <= rd_time;
      hit_val  <= rd_val;
    end
  end

  // slope setup: value step magnitude and sign, time offsets
  assign dy     = {hit_val[VALUE_W-1], hit_val} - {prev_val[VALUE_W-1], prev_val};
  assign dy_neg = (VALUE_W+1)'(0) - dy;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg <= dy[VALUE_W];
      mag <= dy[VALUE_W] ? dy_neg[VALUE_W-1:0] : dy[VALUE_W-1:0];
      dx  <= t_q - prev_time;
      den <= hit_time - prev_time;
    end
  end

  // product and one restoring divide step
  assign prod    = PROD_W'(mag) * PROD_W'(dx);
  assign rem_sh  = {rem, quo[VALUE_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign q_bit   = (rem_sh >= {1'b0, den});

  // divider; quotient fits in VALUE_W bits so the high half starts below den
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem <= prod[PROD_W-1:VALUE_W];
      quo <= prod[VALUE_W-1:0];
    end else if (cmd.div_step) begin
      rem <= q_bit ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      quo <= {quo[VALUE_W-2:0], q_bit};
    end
  end

  // divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.mul) begin
      dcnt <= DCNT_W'(DIV_STEPS);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - DCNT_W'(1);
    end
  end

  // apply the signed step to the left value
  assign interp = neg ? ({{2{prev_val[VALUE_W-1]}}, prev_val} - {2'b00, quo})
                      : ({{2{prev_val[VALUE_W-1]}}, prev_val} + {2'b00, quo});

  // result select
  always_comb begin
    unique case (cmd.res_sel)
      RES_ZERO:   res_mux = '0;
      RES_RD:     res_mux = rd_val;
      RES_LASTV:  res_mux = last_val;
      RES_INTERP: res_mux = interp[VALUE_W-1:0];
      default:    res_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_val    <= res_mux;
      res_region <= cmd.res_region;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value_out <= res_val;
      region    <= res_region;
    end
  end

  // status to the controller
  assign status.n_zero     = (n_use == '0);
  assign status.t_le_rd    = (t_q <= rd_time);
  assign status.t_ge_rd    = (t_q >= rd_time);
  assign status.rd_le_prev = (rd_time <= prev_time);
  assign status.k_last     = (CNT_W'(k) == n_m1);
  assign status.div_last   = (dcnt == DCNT_W'(1));
  assign status.out_free   = !out_valid || !out_stall;

  `PLI_ASSERT_IMP(a_rem_below_den, (dcnt != '0), (rem < den), "divider remainder reached the divisor")
  `PLI_ASSERT_IMP(a_den_nonzero, (dcnt != '0), (den != '0), "division by a zero time span")
  `PLI_ASSERT_NXT(a_out_loaded, cmd.out_load, out_valid, "loaded result not presented")

endmodule

>>> hw/rtl/piecewise_linear_interp.sv
// breakpoint table with clamped linear interpolation, top level
// a write item leaves the block idle and the next item may follow at once; an evaluate item
// loads its result at once for an empty table, after the first or last entry check or the
// scan when clamped, else after the scan, setup, multiply, 32 restoring divide steps and final
// add, or at the scan if bracket times do not rise; input stalls until the result enters the
// output register; synchronous active-high reset clears entry count and control; table undefined until written
`timescale 1ns / 1ps

module piecewise_linear_interp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [plin_pkg::IDX_W-1:0]          entry_index,
  input  logic [plin_pkg::TIME_W-1:0]         entry_time,
  input  logic signed [plin_pkg::VALUE_W-1:0] entry_value,
  input  logic [plin_pkg::TIME_W-1:0]         query_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plin_pkg::VALUE_W-1:0] value_out,
  output logic [1:0]                          region,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plin_pkg::CNT_W-1:0]          cfg_data
);
  import plin_pkg::*;

  plin_cmd_t    cmd;
  plin_status_t status;
  logic         cfg_wr;

  // config write strobe
  assign cfg_wr = cfg_valid && cfg_ready;

  // controller
  plin_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  plin_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr      (cfg_wr),
    .cfg_data    (cfg_data),
    .entry_index (entry_index),
    .entry_time  (entry_time),
    .entry_value (entry_value),
    .query_time  (query_time),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .value_out   (value_out),
    .region      (region)
  );

endmodule

>>> sim/tb_piecewise_linear_interp.sv
// self-checking testbench for the piecewise linear interpolation table
`timescale 1ns / 1ps

module tb_piecewise_linear_interp;
  import plin_pkg::*;

  localparam int unsigned ITEM_TARGET = 1550;

  // one input item as driven on the ports
  typedef struct {
    logic                      mode;
    logic [IDX_W-1:0]          idx;
    logic [TIME_W-1:0]         etime;
    logic signed [VALUE_W-1:0] evalue;
    logic [TIME_W-1:0]         qtime;
  } table_op_t;

  // one result item
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                region;
  } interp_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      mode = MODE_WRITE;
  logic [IDX_W-1:0]          entry_index = '0;
  logic [TIME_W-1:0]         entry_time = '0;
  logic signed [VALUE_W-1:0] entry_value = '0;
  logic [TIME_W-1:0]         query_time = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] value_out;
  logic [1:0]                region;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CNT_W-1:0]          cfg_data = '0;

  // items waiting to be sent and results waiting to arrive
  table_op_t      ops_to_send[$];
  interp_result_t lookup_results_due[$];
  table_op_t      cur_op;
  interp_result_t due;

  // predicted table contents and breakpoint count
  logic [TIME_W-1:0]         bp_time[TABLE_DEPTH];
  logic signed [VALUE_W-1:0] bp_value[TABLE_DEPTH];
  logic [CNT_W-1:0]          bp_count = '0;

  // stimulus side view of the table, used to aim queries
  logic [TIME_W-1:0] plan_time[TABLE_DEPTH];
  int unsigned       plan_count = 0;

  int unsigned item_total = 0;
  int unsigned error_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_len = 0;
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;

  piecewise_linear_interp DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .entry_index (entry_index),
    .entry_time  (entry_time),
    .entry_value (entry_value),
    .query_time  (query_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value_out   (value_out),
    .region      (region),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #25_000_000;
    $display("tb: failure");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // expected behavior of one accepted item
  function automatic void predict_lookup(input table_op_t op);
    int unsigned        n;
    int unsigned        k;
    logic [63:0]        t, t0, t1, mag, prod, quot;
    logic signed [63:0] p0, p1, dy, acc;
    interp_result_t     res;
    if (op.mode == MODE_WRITE) begin
      bp_time[op.idx] = op.etime;
      bp_value[op.idx] = op.evalue;
      return;
    end
    n = (bp_count > DEPTH_CNT) ? TABLE_DEPTH : bp_count;
    t = 64'(op.qtime);
    if (n == 0) begin
      res.value = '0;
      res.region = REGION_EMPTY;
    end else if (t <= bp_time[0]) begin
      res.value = bp_value[0];
      res.region = REGION_FIRST;
    end else if (t >= bp_time[n-1]) begin
      res.value = bp_value[n-1];
      res.region = REGION_LAST;
    end else begin
      res.value = bp_value[n-1];
      res.region = REGION_LAST;
      // first breakpoint at or above the query closes the bracket
      for (k = 1; k < n; k++) begin
        if (t <= bp_time[k]) begin
          t0 = bp_time[k-1];
          t1 = bp_time[k];
          p0 = bp_value[k-1];
          p1 = bp_value[k];
          res.region = REGION_INTERP;
          if (t1 <= t0) begin
            res.value = bp_value[k];
          end else begin
            // magnitude product over the span, truncated toward zero
            dy = p1 - p0;
            mag = (dy < 0) ? 64'(-dy) : 64'(dy);
            prod = mag * (t - t0);
            quot = prod / (t1 - t0);
            acc = (dy < 0) ? p0 - $signed(quot) : p0 + $signed(quot);
            res.value = acc[VALUE_W-1:0];
          end
          break;
        end
      end
    end
    lookup_results_due.insert(lookup_results_due.size(), res);
  endfunction

  // stimulus helpers
  function automatic void push_write(input int unsigned idx, input logic [TIME_W-1:0] t,
                                     input logic signed [VALUE_W-1:0] v);
    table_op_t op;
    op.mode = MODE_WRITE;
    op.idx = IDX_W'(idx);
    op.etime = t;
    op.evalue = v;
    op.qtime = $urandom();
    plan_time[idx] = t;
    ops_to_send.insert(ops_to_send.size(), op);
    item_total++;
  endfunction

  function automatic void push_eval(input logic [TIME_W-1:0] q);
    table_op_t op;
    op.mode = MODE_EVAL;
    op.idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    op.etime = $urandom();
    op.evalue = $urandom();
    op.qtime = q;
    ops_to_send.insert(ops_to_send.size(), op);
    item_total++;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -1;
      4: return VALUE_W'($signed($urandom_range(0, 511)) - 256);
      default: return $urandom();
    endcase
  endfunction

  // query aimed at the planned table: ends, exact hits, neighbors, inside, or random
  function automatic logic [TIME_W-1:0] pick_query();
    int unsigned n;
    int unsigned k;
    n = plan_count;
    if (n == 0) return $urandom();
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return plan_time[k];
      4: return plan_time[k] + 1;
      5: return plan_time[k] - 1;
      9: return $urandom();
      default: return $urandom_range(plan_time[0], plan_time[n-1]);
    endcase
  endfunction

  // full table reload: spread, narrow, wide steps, or unordered times
  function automatic void load_table(input int unsigned style);
    logic [TIME_W-1:0] t[$];
    logic [TIME_W-1:0] nxt;
    int unsigned       i;
    case (style)
      0: begin
        for (i = 0; i < TABLE_DEPTH; i++) t.insert(t.size(), $urandom());
        t.sort();
        for (i = 1; i < TABLE_DEPTH; i++)
          if (t[i] <= t[i-1]) t[i] = t[i-1] + 1;
      end
      1: begin
        nxt = $urandom_range(0, 32'hFFFF_FF00);
        for (i = 0; i < TABLE_DEPTH; i++) begin
          t.insert(t.size(), nxt);
          nxt = nxt + $urandom_range(1, 8);
        end
      end
      2: begin
        nxt = $urandom_range(0, 255);
        for (i = 0; i < TABLE_DEPTH; i++) begin
          t.insert(t.size(), nxt);
          nxt = nxt + $urandom_range(1, 32'h0FFF_FFFF);
        end
      end
      default: begin
        for (i = 0; i < TABLE_DEPTH; i++) t.insert(t.size(), $urandom());
      end
    endcase
    for (i = 0; i < TABLE_DEPTH; i++) push_write(i, t[i], pick_value());
  endfunction

  // wait until every item is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (ops_to_send.size() != 0 || in_valid || lookup_results_due.size() != 0);
  endtask

  // breakpoint count write, only with the block idle
  task automatic write_count(input logic [CNT_W-1:0] c);
    wait_drained();
    repeat (8) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    plan_count = (c > DEPTH_CNT) ? TABLE_DEPTH : c;
    @(negedge clk);
  endtask

  // input driver, predicts each item as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      bp_count = '0;
    end else begin
      if (cfg_valid && cfg_ready) bp_count = cfg_data;
      if (in_valid && !in_stall) predict_lookup(cur_op);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (ops_to_send.size() > 0) begin
          cur_op = ops_to_send.pop_front();
          in_valid <= 1'b1;
          mode <= cur_op.mode;
          entry_index <= cur_op.idx;
          entry_time <= cur_op.etime;
          entry_value <= cur_op.evalue;
          query_time <= cur_op.qtime;
          gap_left = pick_gap(sender_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lookup_results_due.size() == 0) begin
          $display("%0t: unexpected item, value_out %h region %0d", $time, value_out, region);
          error_count++;
        end else begin
          due = lookup_results_due.pop_front();
          if (value_out !== due.value) begin
            $display("%0t: value_out expected %h actual %h", $time, due.value, value_out);
            error_count++;
          end
          if (region !== due.region) begin
            $display("%0t: region expected %0d actual %0d", $time, due.region, region);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        hold_len = pick_gap(receiver_steady);
        out_stall <= (hold_len != 0);
        stall_left = (hold_len == 0) ? 0 : hold_len - 1;
      end
    end
  end

  // stimulus sequence
  initial begin
    int unsigned      i;
    int unsigned      len;
    int unsigned      sel;
    logic [CNT_W-1:0] c;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table, then a full table of alternating extreme values
    write_count('0);
    push_eval('0);
    push_eval('1);
    for (i = 0; i < TABLE_DEPTH; i++)
      push_write(i, TIME_W'(i * 32'h1111_1111),
                 (i % 2 == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // single breakpoint
    write_count(CNT_W'(1));
    push_eval('0);
    push_eval('1);

    // full table: first bracket, exact hit, mid bracket, at the last entry
    write_count(DEPTH_CNT);
    push_eval(32'h0000_0001);
    push_eval(32'h7777_7777);
    push_eval(32'h3999_9999);
    push_eval('1);

    // count above the depth
    write_count('1);
    push_eval(32'h8888_8888);

    // random phases, each starting from an idle block
    while (item_total < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0, 1: c = '0;
        2, 3: c = CNT_W'(1);
        4, 5: c = CNT_W'(2);
        6, 7, 8: c = DEPTH_CNT;
        9, 10: c = CNT_W'($urandom_range(TABLE_DEPTH + 1, 31));
        default: c = CNT_W'($urandom_range(3, TABLE_DEPTH - 1));
      endcase
      write_count(c);
      sender_steady = ($urandom_range(0, 5) == 0);
      receiver_steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 7) begin
        sel = $urandom_range(0, 19);
        load_table((sel < 7) ? 0 : (sel < 12) ? 1 : (sel < 17) ? 2 : 3);
      end
      len = $urandom_range(30, 90);
      repeat (len) begin
        // mostly queries, with single-entry rewrites mixed in
        if ($urandom_range(0, 4) == 0) begin
          i = $urandom_range(0, TABLE_DEPTH - 1);
          push_write(i, ($urandom_range(0, 9) < 7) ? plan_time[i] : TIME_W'($urandom()),
                     pick_value());
        end else begin
          push_eval(pick_query());
        end
      end
    end

    // drain and let the block settle
    wait_drained();
    repeat (60) @(negedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/plin_pkg.sv
hw/rtl/plin_ctrl.sv
hw/rtl/plin_dp.sv
hw/rtl/piecewise_linear_interp.sv
sim/tb_piecewise_linear_interp.sv
